>>> rtl/tbc_pkg.sv
// Package: widths, register indexes, command and status types for the collision step.
package tbc_pkg;
	localparam int VAL_W = 20;
	localparam int FRAC_BITS_DEF = 8;
	localparam int ADDR_W = 5;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 20'sh7FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 20'sh80000;

	localparam logic [2:0] REG_FIELD_W = 3'd0;
	localparam logic [2:0] REG_FIELD_H = 3'd1;
	localparam logic [2:0] REG_BOX     = 3'd2;
	localparam logic [2:0] REG_MASS0   = 3'd3;
	localparam logic [2:0] REG_MASS1   = 3'd4;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// datapath commands from the controller
	typedef struct packed {
		logic load;     // write one body from the input item
		logic reflect;  // wall reflection and overlap test
		logic div_start;// start division of lane div_lane
		logic [1:0] div_lane;
		logic div_wb;   // write back quotient of lane div_lane
		logic move;     // advance positions
	} tbc_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic hit;
		logic sum_zero;
	} tbc_sts_t;

	function automatic logic signed [VAL_W-1:0] sat20(input logic signed [47:0] v);
		if (v > 48'sd524287) return VAL_MAX;
		if (v < -48'sd524288) return VAL_MIN;
		return v[VAL_W-1:0];
	endfunction
endpackage

>>> rtl/tbc_if.sv
// Valid/ready stream interface carrying one payload.
interface tbc_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/tbc_in_t.sv
// Input and output item payload types.
package tbc_io_pkg;
	typedef struct packed {
		logic func;
		logic body_index;
		logic signed [19:0] load_pos_x;
		logic signed [19:0] load_pos_y;
		logic signed [19:0] load_vel_x;
		logic signed [19:0] load_vel_y;
	} tbc_in_t;
	typedef struct packed {
		logic signed [19:0] body0_x;
		logic signed [19:0] body0_y;
		logic signed [19:0] body1_x;
		logic signed [19:0] body1_y;
		logic overlap_hit;
	} tbc_out_t;
endpackage

>>> rtl/tbc_div.sv
// Restoring divider, one quotient bit a cycle, with round to nearest ties away from zero.
module tbc_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [30:0] num,
	input  logic [8:0] den,
	output logic busy,
	output logic signed [30:0] quo
);
	localparam int NW = 31;
	logic [NW-1:0] mag_q;
	logic [NW-1:0] q_q;
	logic [9:0]    rem_q;
	logic [8:0]    den_q;
	logic          neg_q;
	logic [4:0]    cnt_q;
	logic [9:0]    rem_sh;
	logic [NW-1:0] num_abs;
	logic [NW:0]   qr;

	assign num_abs = num[NW-1] ? NW'(-num) : NW'(num);
	assign rem_sh = {rem_q[8:0], mag_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= 5'(NW);
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// add half divisor up front so truncation rounds
			mag_q <= num_abs + NW'(den >> 1);
			den_q <= den;
			neg_q <= num[NW-1];
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy) begin
			mag_q <= {mag_q[NW-2:0], 1'b0};
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sh - {1'b0, den_q};
				q_q   <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q   <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign qr  = {1'b0, q_q};
	assign quo = neg_q ? NW'(-qr) : NW'(qr);
endmodule

>>> rtl/tbc_dp.sv
// Datapath: body state, reflection, overlap test, collision numerators, motion step.
module tbc_dp #(
	parameter int FRAC_BITS = tbc_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  tbc_pkg::tbc_cmd_t cmd,
	output tbc_pkg::tbc_sts_t sts,
	input  tbc_io_pkg::tbc_in_t in_item,
	input  logic [10:0] field_width,
	input  logic [10:0] field_height,
	input  logic [7:0]  box_size,
	input  logic [7:0]  mass_first,
	input  logic [7:0]  mass_second,
	output logic signed [19:0] pos_x [2],
	output logic signed [19:0] pos_y [2]
);
	import tbc_pkg::*;
	logic signed [19:0] px_q [2];
	logic signed [19:0] py_q [2];
	logic signed [19:0] vx_q [2];
	logic signed [19:0] vy_q [2];
	logic hit_q;
	logic signed [31:0] side, fw, fh;
	logic signed [8:0] m0, m1;
	logic signed [30:0] numer;
	logic signed [19:0] va, vb;
	logic signed [30:0] quo;
	logic busy;
	logic signed [19:0] nv_q [4];
	logic commit_q;

	assign side = 32'(box_size) <<< FRAC_BITS;
	assign fw   = 32'(field_width) <<< FRAC_BITS;
	assign fh   = 32'(field_height) <<< FRAC_BITS;
	assign m0   = 9'(mass_first);
	assign m1   = 9'(mass_second);

	// lane 0: v0x, 1: v0y, 2: v1x, 3: v1y
	always_comb begin
		case (cmd.div_lane)
			2'd0: begin va = vx_q[0]; vb = vx_q[1]; end
			2'd1: begin va = vy_q[0]; vb = vy_q[1]; end
			2'd2: begin va = vx_q[1]; vb = vx_q[0]; end
			2'd3: begin va = vy_q[1]; vb = vy_q[0]; end
			default: begin va = vx_q[0]; vb = vx_q[1]; end
		endcase
	end

	always_comb begin
		if (cmd.div_lane[1])
			numer = 31'((m1 - m0) * va) + 31'(2 * m0 * vb);
		else
			numer = 31'((m0 - m1) * va) + 31'(2 * m1 * vb);
	end

	tbc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .num(numer),
		.den(9'(mass_first) + 9'(mass_second)), .busy(busy), .quo(quo)
	);

	function automatic logic signed [19:0] step60(input logic signed [19:0] v);
		logic [19:0] a;
		logic [19:0] q;
		a = v[19] ? 20'(-21'(v)) : v;
		q = 20'((36'(a + 20'd30) * 36'd69906) >> 22);
		if (20'(q * 20'd60) > a + 20'd30) q = q - 20'd1;
		return v[19] ? -q : q;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				px_q[i] <= '0; py_q[i] <= '0; vx_q[i] <= '0; vy_q[i] <= '0;
			end
			hit_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				px_q[in_item.body_index] <= in_item.load_pos_x;
				py_q[in_item.body_index] <= in_item.load_pos_y;
				vx_q[in_item.body_index] <= in_item.load_vel_x;
				vy_q[in_item.body_index] <= in_item.load_vel_y;
				hit_q <= 1'b0;
			end
			if (cmd.reflect) begin
				for (int i = 0; i < 2; i++) begin
					if (32'(px_q[i]) + side >= fw || px_q[i] <= 0)
						vx_q[i] <= sat20(-48'(vx_q[i]));
					if (32'(py_q[i]) + side >= fh || py_q[i] <= 0)
						vy_q[i] <= sat20(-48'(vy_q[i]));
				end
				hit_q <= (32'(px_q[0]) < 32'(px_q[1]) + side) &&
					(32'(px_q[0]) + side > 32'(px_q[1])) &&
					(32'(py_q[0]) < 32'(py_q[1]) + side) &&
					(32'(py_q[0]) + side > 32'(py_q[1]));
			end
			if (commit_q) begin
				vx_q[0] <= nv_q[0]; vy_q[0] <= nv_q[1];
				vx_q[1] <= nv_q[2]; vy_q[1] <= nv_q[3];
			end
			if (cmd.move) begin
				for (int i = 0; i < 2; i++) begin
					px_q[i] <= sat20(48'(px_q[i]) + 48'(step60(vx_q[i])));
					py_q[i] <= sat20(48'(py_q[i]) + 48'(step60(vy_q[i])));
				end
			end
		end
	end

	// quotients parked until all four lanes are done (lanes read old velocities)
	always_ff @(posedge clk) begin
		if (cmd.div_wb) nv_q[cmd.div_lane] <= sat20(48'(quo));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) commit_q <= 1'b0;
		else commit_q <= cmd.div_wb && cmd.div_lane == 2'd3;
	end

	assign sts.div_busy = busy || commit_q;
	assign sts.hit      = hit_q;
	assign sts.sum_zero = (mass_first == 8'd0) && (mass_second == 8'd0);
	assign pos_x = px_q;
	assign pos_y = py_q;
endmodule

>>> rtl/tbc_ctrl.sv
// Controller: sequences load, reflection, four divisions (on an overlap with nonzero mass sum) and the motion step.
module tbc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_func,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output tbc_pkg::tbc_cmd_t cmd,
	input  tbc_pkg::tbc_sts_t sts
);
	import tbc_pkg::*;
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001, S_REFL = 6'b000010, S_DIVS = 6'b000100,
		S_DIVW = 6'b001000, S_MOVE = 6'b010000, S_OUT = 6'b100000
	} state_t;
	state_t st_q;
	logic [1:0] lane_q;

	assign in_ready  = (st_q == S_IDLE);
	assign out_valid = (st_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.div_lane = lane_q;
		cmd.load = (st_q == S_IDLE) && in_valid && in_func == FUNC_LOAD;
		cmd.reflect = (st_q == S_REFL);
		cmd.div_start = (st_q == S_DIVS) && sts.hit && !sts.sum_zero;
		cmd.div_wb = (st_q == S_DIVW) && !sts.div_busy;
		// hold the move until the new velocities are in place
		cmd.move = (st_q == S_MOVE) && !sts.div_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			lane_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: if (in_valid) st_q <= (in_func == FUNC_TICK) ? S_REFL : S_OUT;
				S_REFL: begin
					lane_q <= '0;
					st_q <= S_DIVS;
				end
				S_DIVS: begin
					if (!sts.hit || sts.sum_zero) st_q <= S_MOVE;
					else st_q <= S_DIVW;
				end
				S_DIVW: begin
					if (!sts.div_busy) begin
						if (lane_q == 2'd3) st_q <= S_MOVE;
						else begin
							lane_q <= lane_q + 2'd1;
							st_q <= S_DIVS;
						end
					end
				end
				S_MOVE: if (!sts.div_busy) st_q <= S_OUT;
				S_OUT: if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/two_body_box_collision_step_top.sv
// Top level: APB register file, item channels, controller and datapath.
// A load item goes straight to its result; a tick runs the reflection and overlap test,
// then four passes of the 31-bit serial divider by the mass sum when the boxes overlap
// and the mass sum is not zero, then the motion step. One item is in flight at a time.
module two_body_box_collision_step_top #(
	parameter int FRAC_BITS = tbc_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tbc_if.sink   in_ch,
	tbc_if.source out_ch,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [tbc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import tbc_pkg::*;
	import tbc_io_pkg::*;
	logic [10:0] fw_q, fh_q;
	logic [7:0] box_q, m0_q, m1_q;
	tbc_cmd_t cmd;
	tbc_sts_t sts;
	logic signed [19:0] px [2];
	logic signed [19:0] py [2];
	tbc_in_t it;
	tbc_out_t ot;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign ridx = paddr[4:2];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 11'd640; fh_q <= 11'd360; box_q <= 8'd50; m0_q <= 8'd75; m1_q <= 8'd75;
		end else if (psel && penable && pwrite && pready) begin
			case (ridx)
				REG_FIELD_W: fw_q <= pwdata[10:0];
				REG_FIELD_H: fh_q <= pwdata[10:0];
				REG_BOX:     box_q <= pwdata[7:0];
				REG_MASS0:   m0_q <= pwdata[7:0];
				REG_MASS1:   m1_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (ridx)
			REG_FIELD_W: prdata = 32'(fw_q);
			REG_FIELD_H: prdata = 32'(fh_q);
			REG_BOX:     prdata = 32'(box_q);
			REG_MASS0:   prdata = 32'(m0_q);
			REG_MASS1:   prdata = 32'(m1_q);
			default:     prdata = '0;
		endcase
	end

	assign it = in_ch.data;

	tbc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_func(it.func),
		.in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd(cmd), .sts(sts)
	);

	tbc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .in_item(it),
		.field_width(fw_q), .field_height(fh_q), .box_size(box_q),
		.mass_first(m0_q), .mass_second(m1_q), .pos_x(px), .pos_y(py)
	);

	logic tick_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tick_q <= 1'b0;
		else if (in_ch.valid && in_ch.ready) tick_q <= it.func;
	end

	assign ot.body0_x = px[0];
	assign ot.body0_y = py[0];
	assign ot.body1_x = px[1];
	assign ot.body1_y = py[1];
	assign ot.overlap_hit = tick_q && sts.hit;
	assign out_ch.data = ot;

	a_no_overlap_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
	a_load_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !tick_q) |-> !ot.overlap_hit) else $error("load reported hit");
	a_wb_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_wb |-> !sts.div_busy) else $error("quotient taken while busy");
endmodule

>>> bench/tbc_checker.sv
// Checker: watches both item channels, predicts each result and compares it.
module tbc_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  tbc_io_pkg::tbc_in_t in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  tbc_io_pkg::tbc_out_t out_data,
	input  logic cfg_we,
	input  logic [2:0] cfg_idx,
	input  logic [31:0] cfg_val,
	output int fail_count,
	output int pending,
	output int results_seen,
	output int hits_seen
);
	import tbc_pkg::*;
	import tbc_io_pkg::*;

	localparam int FB = FRAC_BITS_DEF;

	logic [10:0] fw_q, fh_q;
	logic [7:0] box_q, m0_q, m1_q;
	logic signed [19:0] px[2], py[2], vx[2], vy[2];
	tbc_out_t pos_queue[$];

	function automatic logic signed [19:0] clamp20(input longint v);
		if (v > 524287) return 20'sh7FFFF;
		if (v < -524288) return 20'sh80000;
		return v[19:0];
	endfunction

	function automatic longint round_div(input longint n, input longint d);
		if (n >= 0) return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	task automatic advance_bodies(input tbc_in_t it);
		longint side, ex, ey, ax, ay, bx, by, m0, m1, s;
		tbc_out_t r;
		logic hit;
		hit = 1'b0;
		if (it.func == FUNC_LOAD) begin
			px[it.body_index] = it.load_pos_x;
			py[it.body_index] = it.load_pos_y;
			vx[it.body_index] = it.load_vel_x;
			vy[it.body_index] = it.load_vel_y;
		end else begin
			side = longint'(box_q) << FB;
			ex = longint'(fw_q) << FB;
			ey = longint'(fh_q) << FB;
			for (int i = 0; i < 2; i++) begin
				if (px[i] + side >= ex || px[i] <= 0) vx[i] = clamp20(-longint'(vx[i]));
				if (py[i] + side >= ey || py[i] <= 0) vy[i] = clamp20(-longint'(vy[i]));
			end
			if (px[0] < px[1] + side && px[0] + side > px[1] &&
				py[0] < py[1] + side && py[0] + side > py[1]) begin
				hit = 1'b1;
				m0 = m0_q;
				m1 = m1_q;
				s = m0 + m1;
				if (s != 0) begin
					ax = vx[0]; ay = vy[0]; bx = vx[1]; by = vy[1];
					vx[0] = clamp20(round_div((m0 - m1) * ax + 2 * m1 * bx, s));
					vy[0] = clamp20(round_div((m0 - m1) * ay + 2 * m1 * by, s));
					vx[1] = clamp20(round_div((m1 - m0) * bx + 2 * m0 * ax, s));
					vy[1] = clamp20(round_div((m1 - m0) * by + 2 * m0 * ay, s));
				end
			end
			for (int i = 0; i < 2; i++) begin
				px[i] = clamp20(px[i] + round_div(vx[i], 60));
				py[i] = clamp20(py[i] + round_div(vy[i], 60));
			end
		end
		r.body0_x = px[0];
		r.body0_y = py[0];
		r.body1_x = px[1];
		r.body1_y = py[1];
		r.overlap_hit = hit;
		pos_queue.push_back(r);
	endtask

	task automatic compare_result(input tbc_out_t got);
		tbc_out_t want;
		if (pos_queue.size() == 0) begin
			$display("result with nothing expected");
			fail_count++;
			return;
		end
		want = pos_queue.pop_front();
		if (got.body0_x !== want.body0_x) report_mismatch("body0_x", got.body0_x, want.body0_x);
		if (got.body0_y !== want.body0_y) report_mismatch("body0_y", got.body0_y, want.body0_y);
		if (got.body1_x !== want.body1_x) report_mismatch("body1_x", got.body1_x, want.body1_x);
		if (got.body1_y !== want.body1_y) report_mismatch("body1_y", got.body1_y, want.body1_y);
		if (got.overlap_hit !== want.overlap_hit)
			report_mismatch("overlap_hit", got.overlap_hit, want.overlap_hit);
		if (want.overlap_hit) hits_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 11'd640;
			fh_q <= 11'd360;
			box_q <= 8'd50;
			m0_q <= 8'd75;
			m1_q <= 8'd75;
			for (int i = 0; i < 2; i++) begin
				px[i] = '0; py[i] = '0; vx[i] = '0; vy[i] = '0;
			end
			pos_queue.delete();
			fail_count <= 0;
			results_seen <= 0;
			hits_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_FIELD_W: fw_q <= cfg_val[10:0];
					REG_FIELD_H: fh_q <= cfg_val[10:0];
					REG_BOX: box_q <= cfg_val[7:0];
					REG_MASS0: m0_q <= cfg_val[7:0];
					REG_MASS1: m1_q <= cfg_val[7:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) advance_bodies(in_data);
			if (out_valid && out_ready) begin
				compare_result(out_data);
				results_seen <= results_seen + 1;
			end
		end
	end

	assign pending = pos_queue.size();
endmodule

>>> bench/tb.sv
// Testbench top: clock, reset, register writes, item stimulus and verdict.
module tb;
	import tbc_pkg::*;
	import tbc_io_pkg::*;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	int fail_count, pending, results_seen, hits_seen;
	int items_sent;
	bit idle_on;

	tbc_if #(.T(tbc_in_t)) in_ch ();
	tbc_if #(.T(tbc_out_t)) out_ch ();

	two_body_box_collision_step_top i_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	tbc_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.cfg_we(psel && penable && pwrite && pready), .cfg_idx(paddr[4:2]),
		.cfg_val(pwdata), .fail_count(fail_count), .pending(pending),
		.results_seen(results_seen), .hits_seen(hits_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sink side: stall in random bursts while idling is on
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic send_item(input tbc_in_t it);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_ch.data <= it;
		in_ch.valid <= 1'b1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic idle_line();
		in_ch.valid <= 1'b0;
	endtask

	function automatic tbc_in_t load_item(input logic b, input int x, input int y,
			input int vx, input int vy);
		tbc_in_t it;
		it.func = FUNC_LOAD;
		it.body_index = b;
		it.load_pos_x = x[19:0];
		it.load_pos_y = y[19:0];
		it.load_vel_x = vx[19:0];
		it.load_vel_y = vy[19:0];
		return it;
	endfunction

	function automatic tbc_in_t tick_item();
		tbc_in_t it;
		it = tbc_in_t'({$urandom, $urandom, $urandom});
		it.func = FUNC_TICK;
		return it;
	endfunction

	function automatic int rand_val();
		return $signed(20'($urandom));
	endfunction

	// positions inside the field
	function automatic int rand_pos(input int span);
		return $urandom_range(0, span << 8);
	endfunction

	task automatic random_phase(input int n, input int fw, input int fh);
		int k;
		k = 0;
		while (k < n) begin
			case ($urandom_range(0, 9))
				0: begin
					send_item(load_item($urandom, rand_val(), rand_val(), rand_val(),
						rand_val()));
					k++;
				end
				1, 2: begin
					send_item(load_item($urandom, rand_pos(fw), rand_pos(fh),
						$signed(16'($urandom)) * 4, $signed(16'($urandom)) * 4));
					k++;
				end
				3: begin
					// place both bodies near one spot, heading toward each other, so they may overlap
					send_item(load_item(1'b0, (fw << 7) - 2000, (fh << 7),
						$urandom_range(0, 60000), $signed(16'($urandom))));
					send_item(load_item(1'b1, (fw << 7) + $urandom_range(0, 3000),
						(fh << 7) + $urandom_range(0, 3000) - 1500,
						-$urandom_range(0, 60000), $signed(16'($urandom))));
					k += 2;
				end
				default: begin
					send_item(tick_item());
					k++;
				end
			endcase
		end
		idle_line();
	endtask

	initial begin
		int fw, fh;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		idle_on = 1'b1;
		items_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, extremes of the fields, saturation
		send_item(tick_item());
		send_item(load_item(1'b0, 524287, -524288, -524288, 524287));
		send_item(load_item(1'b1, -524288, 524287, 524287, -524288));
		send_item(tick_item());
		send_item(load_item(1'b0, 100 << 8, 100 << 8, 6000, -3000));
		send_item(load_item(1'b1, 130 << 8, 120 << 8, -9000, 4500));
		send_item(tick_item());
		send_item(tick_item());
		send_item(load_item(1'b0, 0, 0, 0, 0));
		send_item(load_item(1'b1, 590 << 8, 310 << 8, 1000, 1000));
		send_item(tick_item());
		send_item(load_item(1'b1, 524287, 524287, -524288, -524288));
		send_item(tick_item());
		idle_line();
		drain();

		// overlap with one zero mass, then both masses zero
		write_reg(REG_MASS0, 32'd0);
		send_item(load_item(1'b0, 10 << 8, 10 << 8, 7000, -7000));
		send_item(load_item(1'b1, 20 << 8, 20 << 8, -500, 300));
		send_item(tick_item());
		idle_line();
		drain();
		write_reg(REG_MASS1, 32'hFFFF_FF00);
		send_item(tick_item());
		send_item(load_item(1'b0, 10 << 8, 10 << 8, 524287, -524288));
		send_item(tick_item());
		idle_line();
		drain();

		// extremes of the registers, high bits of pwdata ignored
		write_reg(REG_FIELD_W, 32'hFFFF_FFFF);
		write_reg(REG_FIELD_H, 32'd1);
		write_reg(REG_BOX, 32'd255);
		write_reg(REG_MASS0, 32'd255);
		write_reg(REG_MASS1, 32'd1);
		random_phase(60, 2047, 1);
		drain();

		write_reg(REG_FIELD_W, 32'd1);
		write_reg(REG_FIELD_H, 32'd2047);
		write_reg(REG_BOX, 32'd1);
		write_reg(REG_MASS0, 32'd1);
		write_reg(REG_MASS1, 32'd255);
		random_phase(60, 1, 2047);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			fw = $urandom_range(100, 2047);
			fh = $urandom_range(100, 2047);
			write_reg(REG_FIELD_W, fw);
			write_reg(REG_FIELD_H, fh);
			write_reg(REG_BOX, $urandom_range(1, 255));
			write_reg(REG_MASS0, $urandom_range(0, 255));
			write_reg(REG_MASS1, $urandom_range(1, 255));
			if (ph == 4) idle_on = 1'b0;
			random_phase(350, fw, fh);
			drain();
		end

		$display("covered %0d items and %0d results, %0d of them with an overlap",
			items_sent, results_seen, hits_seen);
		$display("register settings included field, box and mass extremes and zero masses");
		if (fail_count == 0) begin
			$display("two_body_box_collision_step_top test passed");
		end else begin
			$display("two_body_box_collision_step_top test failed");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("two_body_box_collision_step_top test failed");
		$finish;
	end
endmodule

>>> filelist.f
rtl/tbc_pkg.sv
rtl/tbc_if.sv
rtl/tbc_in_t.sv
rtl/tbc_div.sv
rtl/tbc_dp.sv
rtl/tbc_ctrl.sv
rtl/two_body_box_collision_step_top.sv
bench/tbc_checker.sv
bench/tb.sv
